/* src/orom_pkg.sv */
`timescale 1ns / 1ps

package orom_pkg;

	// point states
	localparam logic [1:0] ST_NORMAL = 2'd0;
	localparam logic [1:0] ST_HIGH   = 2'd1;
	localparam logic [1:0] ST_LOW    = 2'd2;
	localparam logic [1:0] ST_FAULT  = 2'd3;

	// event codes beyond the state codes
	localparam logic [2:0] EV_ESC   = 3'd4;
	localparam logic [2:0] TGT_NONE = 3'd4;

	// opcodes
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_ACK    = 2'd2;
	localparam logic [1:0] OP_MAINT  = 2'd3;

	// configuration register indexes
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] CFG_LIM_HI          = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_LIM_LO          = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_DEADBAND        = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_DELAY_OFFNORMAL = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_DELAY_NORMAL    = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_ESCALATE_AFTER  = 3'd5;

	localparam logic [31:0] SAME_DELAY = 32'hFFFF_FFFF;

	// notifications per item and default note queue depth
	localparam int NOTE_MAX       = 3;
	localparam int NOTE_DEPTH_DEF = 4;

	typedef struct packed {
		logic [31:0] lim_hi;
		logic [31:0] lim_lo;
		logic [30:0] deadband;
		logic [31:0] delay_offnormal;
		logic [31:0] delay_normal;
		logic [31:0] escalate_after;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] now_time;
		logic [31:0] sample_value;
		logic        probe_fault;
		logic        maint_on;
	} item_t;

	typedef struct packed {
		logic [2:0]  code;
		logic [31:0] ev_time;
		logic [31:0] ev_value;
		logic [1:0]  pstate;
		logic        last;
	} note_t;

	typedef struct packed {
		logic [1:0]                 cnt;
		logic [NOTE_MAX-1:0][$bits(note_t)-1:0] notes;
	} note_push_t;

endpackage

/* src/orom_note_fifo.sv */
`timescale 1ns / 1ps

module orom_note_fifo #(
	parameter int DEPTH = orom_pkg::NOTE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  orom_pkg::note_push_t push,
	output logic [1:0]          free,
	output logic                out_valid,
	input  logic                out_stall,
	output orom_pkg::note_t     head
);
	import orom_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = PW + 2;

	note_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  room;
	logic           pop;

	function automatic logic [PW-1:0] f_wrap(logic [PW-1:0] p, logic [1:0] k);
		logic [SW-1:0] s;
		s = SW'(p) + SW'(k);
		if (s >= SW'(DEPTH))
			s = s - SW'(DEPTH);
		return s[PW-1:0];
	endfunction

	assign pop       = out_valid && !out_stall;
	assign out_valid = (cnt_q != '0);
	assign head      = mem_q[rd_q];
	assign room      = CW'(DEPTH) - cnt_q;
	assign free      = (room >= CW'(NOTE_MAX)) ? 2'(NOTE_MAX) : room[1:0];

	always_ff @(posedge clk) begin
		for (int i = 0; i < NOTE_MAX; i++) begin
			if (2'(i) < push.cnt)
				mem_q[f_wrap(wr_q, 2'(i))] <= note_t'(push.notes[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= f_wrap(wr_q, push.cnt);
			if (pop)
				rd_q <= f_wrap(rd_q, 2'd1);
			cnt_q <= cnt_q + CW'(push.cnt) - CW'(pop);
		end
	end

endmodule

/* src/orom_core.sv */
`timescale 1ns / 1ps

module orom_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  orom_pkg::cfg_t       cfg,
	input  logic                 item_valid,
	input  orom_pkg::item_t      item,
	input  logic [1:0]           free,
	output logic                 done,
	output orom_pkg::note_push_t push
);
	import orom_pkg::*;

	typedef struct packed {
		logic [1:0]  cur;
		logic [1:0]  notified;
		logic [1:0]  ptarget;
		logic        pvalid;
		logic        unacked;
		logic        escalated;
		logic        maint;
		logic [31:0] psince;
		logic [31:0] estart;
	} alarm_st_t;

	typedef struct packed {
		alarm_st_t                  st;
		logic [1:0]                 cnt;
		logic [NOTE_MAX-1:0][2:0]   code;
		logic [NOTE_MAX-1:0][1:0]   pstate;
	} work_t;

	alarm_st_t   st_q;
	logic [31:0] latest_q;
	logic [31:0] recent_q;

	work_t       w;
	logic [31:0] latest_d;
	logic [31:0] recent_d;
	logic [2:0]  tgt;
	logic        stale;
	note_t       nt;

	function automatic work_t f_emit(work_t wi, logic [2:0] c);
		work_t r;
		r = wi;
		if (wi.cnt < 2'(NOTE_MAX)) begin
			r.code[wi.cnt]   = c;
			r.pstate[wi.cnt] = wi.st.cur;
			r.cnt            = wi.cnt + 2'd1;
		end
		return r;
	endfunction

	function automatic work_t f_notify(work_t wi, logic [31:0] now);
		work_t r;
		r = f_emit(wi, {1'b0, wi.st.cur});
		r.st.notified = r.st.cur;
		if (r.st.cur == ST_HIGH || r.st.cur == ST_LOW) begin
			r.st.unacked   = 1'b1;
			r.st.estart    = now;
			r.st.escalated = 1'b0;
		end
		return r;
	endfunction

	function automatic work_t f_goto(work_t wi, logic [1:0] to, logic [31:0] now);
		work_t r;
		r = wi;
		r.st.cur    = to;
		r.st.pvalid = 1'b0;
		if (!r.st.maint)
			r = f_notify(r, now);
		return r;
	endfunction

	function automatic work_t f_timer(work_t wi, logic [31:0] now, cfg_t c);
		work_t       r;
		logic [31:0] d;
		logic [31:0] elapsed;
		r = wi;
		d = (wi.st.ptarget == ST_NORMAL && c.delay_normal != SAME_DELAY) ?
			c.delay_normal : c.delay_offnormal;
		elapsed = now - wi.st.psince;
		if (wi.st.cur != ST_FAULT && wi.st.pvalid && elapsed >= d)
			r = f_goto(wi, wi.st.ptarget, now);
		return r;
	endfunction

	function automatic work_t f_escalate(work_t wi, logic [31:0] now, cfg_t c);
		work_t       r;
		logic [31:0] elapsed;
		r = wi;
		elapsed = now - wi.st.estart;
		if (wi.st.unacked && !wi.st.escalated && !wi.st.maint &&
			c.escalate_after != '0 && elapsed >= c.escalate_after) begin
			r = f_emit(wi, EV_ESC);
			r.st.escalated = 1'b1;
		end
		return r;
	endfunction

	// limits widened so that the deadband never wraps them
	function automatic logic [2:0] f_target(logic [1:0] cur, logic [31:0] v, cfg_t c);
		logic signed [33:0] v34;
		logic signed [33:0] hi;
		logic signed [33:0] lo;
		logic signed [33:0] db;
		logic [2:0]         t;
		v34 = {{2{v[31]}}, v};
		hi  = {{2{c.lim_hi[31]}}, c.lim_hi};
		lo  = {{2{c.lim_lo[31]}}, c.lim_lo};
		db  = {3'b000, c.deadband};
		t   = TGT_NONE;
		unique case (cur)
			ST_NORMAL: begin
				priority if (v34 > hi)
					t = {1'b0, ST_HIGH};
				else if (v34 < lo)
					t = {1'b0, ST_LOW};
				else
					t = TGT_NONE;
			end
			ST_HIGH: begin
				priority if (v34 < lo)
					t = {1'b0, ST_LOW};
				else if (v34 < hi - db)
					t = {1'b0, ST_NORMAL};
				else
					t = TGT_NONE;
			end
			ST_LOW: begin
				priority if (v34 > hi)
					t = {1'b0, ST_HIGH};
				else if (v34 > lo + db)
					t = {1'b0, ST_NORMAL};
				else
					t = TGT_NONE;
			end
			ST_FAULT: t = TGT_NONE;
		endcase
		return t;
	endfunction

	assign stale = (item.now_time < latest_q);

	always_comb begin
		w        = '0;
		w.st     = st_q;
		latest_d = latest_q;
		recent_d = recent_q;
		tgt      = TGT_NONE;
		if (!stale) begin
			latest_d = item.now_time;
			unique case (item.opcode)
				OP_SAMPLE: begin
					recent_d = item.sample_value;
					if (item.probe_fault) begin
						if (w.st.cur != ST_FAULT)
							w = f_goto(w, ST_FAULT, item.now_time);
						w.st.pvalid = 1'b0;
					end else begin
						if (w.st.cur == ST_FAULT)
							w = f_goto(w, ST_NORMAL, item.now_time);
						tgt = f_target(w.st.cur, item.sample_value, cfg);
						if (tgt == TGT_NONE) begin
							w.st.pvalid = 1'b0;
						end else if (!w.st.pvalid || tgt[1:0] != w.st.ptarget) begin
							w.st.pvalid  = 1'b1;
							w.st.ptarget = tgt[1:0];
							w.st.psince  = item.now_time;
						end
						w = f_timer(w, item.now_time, cfg);
					end
				end
				OP_TICK: begin
					w = f_timer(w, item.now_time, cfg);
				end
				OP_ACK: begin
					w = f_timer(w, item.now_time, cfg);
					w.st.unacked = 1'b0;
				end
				OP_MAINT: begin
					w = f_timer(w, item.now_time, cfg);
					if (item.maint_on) begin
						w.st.maint = 1'b1;
					end else if (w.st.maint) begin
						// leaving maintenance: catch up on a missed change
						w.st.maint = 1'b0;
						if (w.st.cur != w.st.notified)
							w = f_notify(w, item.now_time);
					end
				end
			endcase
			w = f_escalate(w, item.now_time, cfg);
		end
	end

	// the item waits until the note queue can take all its notes
	assign done = item_valid && (w.cnt <= free);

	always_comb begin
		push     = '0;
		nt       = '0;
		push.cnt = done ? w.cnt : 2'd0;
		for (int i = 0; i < NOTE_MAX; i++) begin
			nt.code     = w.code[i];
			nt.ev_time  = item.now_time;
			nt.ev_value = recent_d;
			nt.pstate   = w.pstate[i];
			nt.last     = (2'(i) == w.cnt - 2'd1);
			push.notes[i] = nt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			latest_q <= '0;
			recent_q <= '0;
		end else if (done) begin
			st_q     <= w.st;
			latest_q <= latest_d;
			recent_q <= recent_d;
		end
	end

endmodule

/* src/out_of_range_alarm_monitor_top.sv */
`timescale 1ns / 1ps

// Out-of-range alarm monitor for one analog point (normal, high, low, fault).
// An accepted item lands in an input register, where it is evaluated in one
// pass; once the queue has room, all its zero to three notifications are
// written together to a small note queue, whose head drives the output.
// A new item is taken every cycle as long as the queue has room for all the
// notes of the item in the input register; notes leave the queue one per
// cycle while out_stall is low, so the output port sets the sustained rate.
// Configuration registers are written directly and must only change while
// no item is in flight.
module out_of_range_alarm_monitor_top #(
	parameter int NOTE_DEPTH = orom_pkg::NOTE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [orom_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0]              cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               opcode,
	input  logic [31:0]              now_time,
	input  logic signed [31:0]       sample_value,
	input  logic                     probe_fault,
	input  logic                     maint_on,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               event_code,
	output logic [31:0]              event_time,
	output logic signed [31:0]       event_value,
	output logic [1:0]               point_state,
	output logic                     last_note
);
	import orom_pkg::*;

	cfg_t       cfg_q;
	item_t      item_s1;
	logic       valid_s1;
	logic       done;
	logic [1:0] free;
	note_push_t push;
	note_t      head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lim_hi          <= 32'h7FFF_FFFF;
			cfg_q.lim_lo          <= 32'h8000_0000;
			cfg_q.deadband        <= '0;
			cfg_q.delay_offnormal <= '0;
			cfg_q.delay_normal    <= SAME_DELAY;
			cfg_q.escalate_after  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LIM_HI:          cfg_q.lim_hi          <= cfg_data;
				CFG_LIM_LO:          cfg_q.lim_lo          <= cfg_data;
				CFG_DEADBAND:        cfg_q.deadband        <= cfg_data[30:0];
				CFG_DELAY_OFFNORMAL: cfg_q.delay_offnormal <= cfg_data;
				CFG_DELAY_NORMAL:    cfg_q.delay_normal    <= cfg_data;
				CFG_ESCALATE_AFTER:  cfg_q.escalate_after  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = valid_s1 && !done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && !in_stall)
			valid_s1 <= 1'b1;
		else if (done)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.opcode       <= opcode;
			item_s1.now_time     <= now_time;
			item_s1.sample_value <= sample_value;
			item_s1.probe_fault  <= probe_fault;
			item_s1.maint_on     <= maint_on;
		end
	end

	orom_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (valid_s1),
		.item       (item_s1),
		.free       (free),
		.done       (done),
		.push       (push)
	);

	orom_note_fifo #(
		.DEPTH (NOTE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign event_code  = head.code;
	assign event_time  = head.ev_time;
	assign event_value = head.ev_value;
	assign point_state = head.pstate;
	assign last_note   = head.last;

endmodule

/* src/orom_checker.sv */
`timescale 1ns / 1ps

module orom_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  event_code,
	input logic [31:0] event_time,
	input logic [31:0] event_value,
	input logic [1:0]  point_state,
	input logic        last_note
);
	import orom_pkg::*;

	// a held beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code) &&
		$stable(event_time) && $stable(event_value) &&
		$stable(point_state) && $stable(last_note))
		else $error("output beat changed while stalled");

	// a state notification reports the state it moved to
	a_state_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code != EV_ESC |-> point_state == event_code[1:0])
		else $error("notification code and point state disagree");

	// escalation is checked last, so it always closes its item
	a_esc_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == EV_ESC |-> last_note)
		else $error("escalation not the final note of its item");

endmodule

bind out_of_range_alarm_monitor_top orom_checker u_orom_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.event_code  (event_code),
	.event_time  (event_time),
	.event_value (event_value),
	.point_state (point_state),
	.last_note   (last_note)
);

/* bench/alarm_note_checker.sv */
`timescale 1ns / 1ps

module alarm_note_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [orom_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [1:0]                  opcode,
	input  logic [31:0]                 now_time,
	input  logic [31:0]                 sample_value,
	input  logic                        probe_fault,
	input  logic                        maint_on,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [2:0]                  event_code,
	input  logic [31:0]                 event_time,
	input  logic [31:0]                 event_value,
	input  logic [1:0]                  point_state,
	input  logic                        last_note,
	output int                          fail_count,
	output int                          notes_open
);
	import orom_pkg::*;

	// register copies
	logic [31:0] lim_high, lim_low, dly_off, dly_norm, esc_after;
	logic [30:0] lim_band;

	// point state copy
	logic [1:0]  cur_st, told_st, pend_tgt;
	bit          pend_on, unacked, escalated, in_maint;
	logic [31:0] pend_since, episode_t, latest_t, recent_val;

	note_t       item_notes[$];
	note_t       predicted_notes[$];
	note_t       want;

	task automatic add_note(input logic [2:0] code);
		note_t n;
		if (item_notes.size() < NOTE_MAX) begin
			n = '0;
			n.code = code;
			n.pstate = cur_st;
			item_notes.push_back(n);
		end
	endtask

	task automatic announce_state(input logic [31:0] now);
		add_note({1'b0, cur_st});
		told_st = cur_st;
		if (cur_st == ST_HIGH || cur_st == ST_LOW) begin
			unacked = 1'b1;
			episode_t = now;
			escalated = 1'b0;
		end
	endtask

	task automatic enter_state(input logic [1:0] to, input logic [31:0] now);
		cur_st = to;
		pend_on = 1'b0;
		if (!in_maint)
			announce_state(now);
	endtask

	// limits taken wide so that the deadband never wraps them
	function automatic logic [2:0] limit_target(input logic [31:0] v);
		longint hi, lo, db, sv;
		hi = longint'($signed(lim_high));
		lo = longint'($signed(lim_low));
		db = longint'(lim_band);
		sv = longint'($signed(v));
		case (cur_st)
			ST_NORMAL: begin
				if (sv > hi) return {1'b0, ST_HIGH};
				if (sv < lo) return {1'b0, ST_LOW};
			end
			ST_HIGH: begin
				if (sv < lo) return {1'b0, ST_LOW};
				if (sv < hi - db) return {1'b0, ST_NORMAL};
			end
			ST_LOW: begin
				if (sv > hi) return {1'b0, ST_HIGH};
				if (sv > lo + db) return {1'b0, ST_NORMAL};
			end
			default: ;
		endcase
		return TGT_NONE;
	endfunction

	task automatic run_delay_timer(input logic [31:0] now);
		logic [31:0] d;
		if (cur_st != ST_FAULT && pend_on) begin
			d = (pend_tgt == ST_NORMAL && dly_norm != SAME_DELAY) ? dly_norm : dly_off;
			if (32'(now - pend_since) >= d)
				enter_state(pend_tgt, now);
		end
	endtask

	task automatic check_escalation(input logic [31:0] now);
		if (unacked && !escalated && !in_maint && esc_after != 0 &&
		    32'(now - episode_t) >= esc_after) begin
			add_note(EV_ESC);
			escalated = 1'b1;
		end
	endtask

	task automatic step_point(input logic [1:0] op, input logic [31:0] now,
			input logic [31:0] val, input logic flt, input logic mon);
		logic [2:0] tgt;
		item_notes.delete();
		// older times are dropped without any effect
		if (now >= latest_t) begin
			latest_t = now;
			case (op)
				OP_SAMPLE: begin
					recent_val = val;
					if (flt) begin
						if (cur_st != ST_FAULT)
							enter_state(ST_FAULT, now);
						pend_on = 1'b0;
					end else begin
						if (cur_st == ST_FAULT)
							enter_state(ST_NORMAL, now);
						tgt = limit_target(val);
						if (tgt == TGT_NONE) begin
							pend_on = 1'b0;
						end else if (!pend_on || tgt[1:0] != pend_tgt) begin
							pend_on = 1'b1;
							pend_tgt = tgt[1:0];
							pend_since = now;
						end
						run_delay_timer(now);
					end
				end
				OP_TICK: run_delay_timer(now);
				OP_ACK: begin
					run_delay_timer(now);
					unacked = 1'b0;
				end
				default: begin
					run_delay_timer(now);
					if (mon) begin
						in_maint = 1'b1;
					end else if (in_maint) begin
						// leaving maintenance catches up on a silent change
						in_maint = 1'b0;
						if (cur_st != told_st)
							announce_state(now);
					end
				end
			endcase
			check_escalation(now);
			foreach (item_notes[k]) begin
				item_notes[k].ev_time = now;
				item_notes[k].ev_value = recent_val;
				item_notes[k].last = (k == item_notes.size() - 1);
				predicted_notes.push_back(item_notes[k]);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] got);
		if (got !== exp) begin
			$error("%s: expected %0h, got %0h", name, exp, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_high = 32'h7FFF_FFFF;
			lim_low = 32'h8000_0000;
			lim_band = '0;
			dly_off = '0;
			dly_norm = SAME_DELAY;
			esc_after = '0;
			cur_st = ST_NORMAL;
			told_st = ST_NORMAL;
			pend_tgt = ST_NORMAL;
			pend_on = 1'b0;
			unacked = 1'b0;
			escalated = 1'b0;
			in_maint = 1'b0;
			pend_since = '0;
			episode_t = '0;
			latest_t = '0;
			recent_val = '0;
			predicted_notes.delete();
			fail_count = 0;
			notes_open = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LIM_HI:          lim_high = cfg_data;
					CFG_LIM_LO:          lim_low = cfg_data;
					CFG_DEADBAND:        lim_band = cfg_data[30:0];
					CFG_DELAY_OFFNORMAL: dly_off = cfg_data;
					CFG_DELAY_NORMAL:    dly_norm = cfg_data;
					CFG_ESCALATE_AFTER:  esc_after = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (predicted_notes.size() == 0) begin
					$error("note beat with nothing expected: code %0d time %0h",
						event_code, event_time);
					fail_count++;
				end else begin
					want = predicted_notes.pop_front();
					check_field("event_code", 32'(want.code), 32'(event_code));
					check_field("event_time", want.ev_time, event_time);
					check_field("event_value", want.ev_value, event_value);
					check_field("point_state", 32'(want.pstate), 32'(point_state));
					check_field("last_note", 32'(want.last), 32'(last_note));
				end
			end
			if (in_valid && !in_stall)
				step_point(opcode, now_time, sample_value, probe_fault, maint_on);
			notes_open = predicted_notes.size();
		end
	end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import orom_pkg::*;

	localparam logic [31:0] HI_D = 32'h0064_0000;  // 100.0
	localparam logic [31:0] LO_D = 32'hFF9C_0000;  // -100.0
	localparam logic [31:0] DB_D = 32'h0005_0000;  // 5.0
	localparam logic [31:0] MAX_P = 32'h7FFF_FFFF;
	localparam logic [31:0] MIN_N = 32'h8000_0000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CFG_IW-1:0]  cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode = OP_TICK;
	logic [31:0]        now_time = '0;
	logic [31:0]        sample_value = '0;
	logic               probe_fault = 1'b0;
	logic               maint_on = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         event_code;
	logic [31:0]        event_time;
	logic [31:0]        event_value;
	logic [1:0]         point_state;
	logic               last_note;
	int                 fail_count;
	int                 notes_open;

	// limits as last written, used to aim samples at the edges
	logic [31:0] cur_hi = MAX_P, cur_lo = MIN_N, cur_db = '0;
	logic [31:0] now_s = '0;
	int          burst_left = 0;
	bit          hold_req = 1'b0;

	out_of_range_alarm_monitor_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .now_time(now_time), .sample_value(sample_value),
		.probe_fault(probe_fault), .maint_on(maint_on),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_code(event_code), .event_time(event_time), .event_value(event_value),
		.point_state(point_state), .last_note(last_note)
	);

	alarm_note_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .now_time(now_time), .sample_value(sample_value),
		.probe_fault(probe_fault), .maint_on(maint_on),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_code(event_code), .event_time(event_time), .event_value(event_value),
		.point_state(point_state), .last_note(last_note),
		.fail_count(fail_count), .notes_open(notes_open)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// receiver: runs of random stall density, plus one long hold-off on request
	initial begin : receiver
		int run_left, level, hold;
		run_left = 0;
		level = 0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold = 80;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					level = $urandom_range(0, 3);
					run_left = $urandom_range(1, 25);
				end
				run_left--;
				out_stall <= ($urandom_range(0, 3) < level);
			end
		end
	end

	task automatic offer_item(input logic [1:0] op, input logic [31:0] t, input logic [31:0] v,
			input logic flt, input logic mon);
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		now_time <= t;
		sample_value <= v;
		probe_fault <= flt;
		maint_on <= mon;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic pause(input int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// drain every expected note, then let items with no notes leave the pipe
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (notes_open != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(input logic [31:0] hi, input logic [31:0] lo,
			input logic [31:0] db, input logic [31:0] doff, input logic [31:0] dnorm,
			input logic [31:0] esc);
		settle();
		write_reg(CFG_LIM_HI, hi);
		write_reg(CFG_LIM_LO, lo);
		write_reg(CFG_DEADBAND, db);
		write_reg(CFG_DELAY_OFFNORMAL, doff);
		write_reg(CFG_DELAY_NORMAL, dnorm);
		write_reg(CFG_ESCALATE_AFTER, esc);
		cur_hi = hi;
		cur_lo = lo;
		cur_db = {1'b0, db[30:0]};
	endtask

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 11))
			0:  return cur_hi;
			1:  return cur_hi + 1;
			2:  return cur_hi - 1;
			3:  return cur_hi - cur_db;
			4:  return cur_hi - cur_db - 1;
			5:  return cur_lo;
			6:  return cur_lo - 1;
			7:  return cur_lo + 1;
			8:  return cur_lo + cur_db;
			9:  return cur_lo + cur_db + 1;
			10: return $urandom;
			default: begin
				case ($urandom_range(0, 2))
					0: return MAX_P;
					1: return MIN_N;
					default: return '0;
				endcase
			end
		endcase
	endfunction

	task automatic offer_random_item();
		logic [1:0]  op;
		logic [31:0] t, v;
		logic        flt, mon;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 50) op = OP_SAMPLE;
		else if (r < 72) op = OP_TICK;
		else if (r < 86) op = OP_ACK;
		else op = OP_MAINT;
		r = $urandom_range(0, 99);
		if (r < 5 && now_s != 0) begin
			// stale time, dropped by the block
			t = $urandom_range(0, now_s - 1);
		end else begin
			if (r >= 25 && r < 90) now_s += $urandom_range(1, 3);
			else if (r >= 90) now_s += $urandom_range(4, 20);
			t = now_s;
		end
		v = (op == OP_SAMPLE) ? edge_value() : $urandom;
		flt = (op == OP_SAMPLE) ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1));
		mon = ($urandom_range(0, 2) == 0);
		offer_item(op, t, v, flt, mon);
	endtask

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				if ($urandom_range(0, 3) != 0)
					pause($urandom_range(1, 8));
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
			offer_random_item();
		end
	endtask

	initial begin : stimulus
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset limits: only faults can move the point
		offer_item(OP_TICK, 0, '0, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 0, MAX_P, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 0, MIN_N, 1'b0, 1'b0);

		apply_setting(HI_D, LO_D, DB_D, 32'd0, SAME_DELAY, 32'd10);
		offer_item(OP_ACK, 0, '0, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 1, '0, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 2, HI_D + 1, 1'b0, 1'b0);
		// high to low directly
		offer_item(OP_SAMPLE, 3, LO_D - 1, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 4, LO_D + DB_D, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 5, LO_D + DB_D + 1, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 6, HI_D, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 6, HI_D + 1, 1'b0, 1'b0);
		offer_item(OP_TICK, 16, '0, 1'b0, 1'b0);
		offer_item(OP_ACK, 17, '0, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 18, 32'hDEAD_BEEF, 1'b1, 1'b0);
		offer_item(OP_SAMPLE, 19, 32'h1234_5678, 1'b1, 1'b0);
		offer_item(OP_TICK, 19, '0, 1'b0, 1'b0);
		// fault recovery followed by an immediate high
		offer_item(OP_SAMPLE, 20, MAX_P, 1'b0, 1'b0);
		offer_item(OP_MAINT, 21, '0, 1'b0, 1'b1);
		offer_item(OP_SAMPLE, 22, MIN_N, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 23, '0, 1'b1, 1'b1);
		offer_item(OP_SAMPLE, 24, '0, 1'b0, 1'b1);
		offer_item(OP_SAMPLE, 25, MIN_N, 1'b0, 1'b0);
		offer_item(OP_MAINT, 26, '0, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 10, HI_D + 1, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 26, HI_D + 1, 1'b0, 1'b0);
		offer_item(OP_MAINT, 27, '0, 1'b0, 1'b0);
		offer_item(OP_TICK, 40, '0, 1'b0, 1'b0);
		now_s = 40;

		apply_setting(32'h000A_0000, 32'hFFF6_0000, 32'h0001_0000, 32'd3, SAME_DELAY, 32'd8);
		hold_req = 1'b1;
		run_random(56);
		apply_setting(32'h0001_0000, 32'hFFFF_0000, 32'd0, 32'd0, 32'd2, 32'd1);
		run_random(56);
		apply_setting(MAX_P, MIN_N, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		run_random(56);
		// inverted limits
		apply_setting(MIN_N, MAX_P, MAX_P, 32'd1, 32'd0, 32'd3);
		run_random(56);
		apply_setting($urandom, $urandom, $urandom_range(0, 32'h3FFFF), $urandom_range(0, 6),
			($urandom_range(0, 1) == 0) ? SAME_DELAY : 32'($urandom_range(0, 6)),
			$urandom_range(0, 12));
		run_random(56);
		apply_setting(32'd0, 32'd0, 32'h0000_8000, 32'd2, 32'hFFFF_FFFE, 32'd5);
		run_random(56);
		apply_setting($urandom, $urandom, $urandom_range(0, 32'h3FFFF), $urandom_range(0, 6),
			($urandom_range(0, 1) == 0) ? SAME_DELAY : 32'($urandom_range(0, 6)),
			$urandom_range(0, 12));
		run_random(56);

		// top of the time range, last since nothing older is taken after it
		apply_setting(HI_D, LO_D, DB_D, 32'd2, SAME_DELAY, 32'd3);
		offer_item(OP_SAMPLE, 32'hFFFF_FFF0, HI_D + 1, 1'b0, 1'b0);
		offer_item(OP_TICK, 32'hFFFF_FFFE, '0, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 5, LO_D - 1, 1'b0, 1'b0);
		offer_item(OP_SAMPLE, 32'hFFFF_FFFF, '0, 1'b0, 1'b0);
		offer_item(OP_TICK, 32'hFFFF_FFFF, '0, 1'b0, 1'b0);

		settle();
		repeat (12) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
